/* rtl/core/rx_timestamp_transition_calibrator_top_macros.svh */
// Assertion macros shared by the calibrator RTL.
`ifndef RX_TIMESTAMP_TRANSITION_CALIBRATOR_TOP_MACROS_SVH
`define RX_TIMESTAMP_TRANSITION_CALIBRATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define RXTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RXTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rxtc_pkg.sv */
package rxtc_pkg;

   localparam int PHASE_WIDTH    = 15;
   localparam int PERIOD_WIDTH   = 14;
   localparam int STEP_WIDTH     = 8;
   localparam int COUNT_WIDTH    = 4;
   localparam int STATUS_WIDTH   = 2;
   localparam int SETPOINT_WIDTH = 15;
   localparam int TRANS_WIDTH    = 14;
   localparam int PRODUCT_WIDTH  = COUNT_WIDTH + STEP_WIDTH;
   localparam int RANGE_WIDTH    = 16;
   localparam int CMP_WIDTH      = (PHASE_WIDTH > RANGE_WIDTH) ? PHASE_WIDTH : RANGE_WIDTH;
   // Averaging sum: two phases plus half a period, with a sign bit.
   localparam int SUM_WIDTH      = PHASE_WIDTH + 3;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [PERIOD_WIDTH-1:0]  PERIOD_RESET   = 14'd8000;
   localparam logic [STEP_WIDTH-1:0]    STEP_RESET     = 8'd100;
   localparam logic [COUNT_WIDTH-1:0]   DEGLITCH_RESET = 4'd5;

   typedef enum logic [1:0] {
      CSR_PERIOD   = 2'd0,
      CSR_STEP     = 2'd1,
      CSR_DEGLITCH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_INACTIVE = 2'd0,
      MODE_ACTIVE   = 2'd1,
      MODE_DONE     = 2'd2
   } det_mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_SCAN  = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic clear;
      logic feed;
      logic store_norm;
   } det_ctrl_type;

   typedef struct packed {
      det_mode_type           mode_next;
      logic [PHASE_WIDTH-1:0] edge_fed;
      logic [PHASE_WIDTH-1:0] edge_next;
   } det_status_type;

endpackage

/* rtl/core/rxtc_det.sv */
// Deglitching transition detector: an inactive run, then an active run.
module rxtc_det (
   input  logic                                clock,
   input  logic                                reset,
   input  rxtc_pkg::det_ctrl_type              ctrl,
   input  logic                                sample_bit,
   input  logic                                active_level,
   input  logic [rxtc_pkg::COUNT_WIDTH-1:0]    deglitch,
   input  logic [rxtc_pkg::PHASE_WIDTH-1:0]    scan_phase,
   input  logic [rxtc_pkg::PRODUCT_WIDTH-1:0]  product,
   input  logic [rxtc_pkg::PHASE_WIDTH-1:0]    norm_edge,
   output rxtc_pkg::det_status_type            status
);

   rxtc_pkg::det_mode_type mode_ff, mode_in;
   logic [rxtc_pkg::COUNT_WIDTH-1:0] run_ff, run_in, run_inc, run_idle;
   logic [rxtc_pkg::PHASE_WIDTH-1:0] edge_ff, edge_in, edge_fed, edge_calc;
   logic [rxtc_pkg::PHASE_WIDTH:0]   diff;
   logic                             is_active;

   assign is_active = (sample_bit == active_level);
   assign run_inc   = (run_ff == '1) ? run_ff : run_ff + 1'b1;
   assign run_idle  = is_active ? '0 : run_inc;

   // Phase of the edge: the run started deglitch steps ago, clamped at zero.
   assign diff      = {1'b0, scan_phase} - (rxtc_pkg::PHASE_WIDTH + 1)'(product);
   assign edge_calc = diff[rxtc_pkg::PHASE_WIDTH] ? '0 : diff[rxtc_pkg::PHASE_WIDTH-1:0];

   always_comb begin
      mode_in  = mode_ff;
      run_in   = run_ff;
      edge_fed = edge_ff;
      if (ctrl.clear) begin
         mode_in  = rxtc_pkg::MODE_INACTIVE;
         run_in   = '0;
         edge_fed = '0;
      end else if (ctrl.feed) begin
         unique case (mode_ff)
            rxtc_pkg::MODE_INACTIVE: begin
               if (run_idle >= deglitch) begin
                  mode_in = rxtc_pkg::MODE_ACTIVE;
                  run_in  = '0;
               end else begin
                  run_in = run_idle;
               end
            end
            rxtc_pkg::MODE_ACTIVE: begin
               if (!is_active) begin
                  run_in = '0;
               end else begin
                  run_in = run_inc;
                  if (run_inc >= deglitch) begin
                     mode_in  = rxtc_pkg::MODE_DONE;
                     edge_fed = edge_calc;
                  end
               end
            end
            rxtc_pkg::MODE_DONE: begin
               mode_in = mode_ff;
            end
            default: begin
               mode_in = rxtc_pkg::MODE_INACTIVE;
            end
         endcase
      end
      edge_in = ctrl.store_norm ? norm_edge : edge_fed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rxtc_pkg::MODE_INACTIVE;
         run_ff  <= '0;
         edge_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         run_ff  <= run_in;
         edge_ff <= edge_in;
      end
   end

   assign status.mode_next = mode_in;
   assign status.edge_fed  = edge_fed;
   assign status.edge_next = edge_in;

endmodule

/* rtl/core/rxtc_resolve.sv */
// Folds both edge phases into one period and averages them.
module rxtc_resolve (
   input  logic [rxtc_pkg::PERIOD_WIDTH-1:0] period,
   input  logic [rxtc_pkg::PHASE_WIDTH-1:0]  rise_raw,
   input  logic [rxtc_pkg::PHASE_WIDTH-1:0]  fall_raw,
   output logic [rxtc_pkg::PHASE_WIDTH-1:0]  rise_norm,
   output logic [rxtc_pkg::PHASE_WIDTH-1:0]  fall_norm,
   output logic [rxtc_pkg::TRANS_WIDTH-1:0]  transition
);

   logic [rxtc_pkg::PHASE_WIDTH-1:0] per, rise_1, fall_1;
   logic signed [rxtc_pkg::SUM_WIDTH-1:0] sum, half_s, per_s, adj, adj_round, halved, wrapped;

   assign per = rxtc_pkg::PHASE_WIDTH'(period);

   // At most two subtractions of the period.
   assign rise_1    = (rise_raw >= per) ? rise_raw - per : rise_raw;
   assign rise_norm = (rise_1 >= per) ? rise_1 - per : rise_1;
   assign fall_1    = (fall_raw >= per) ? fall_raw - per : fall_raw;
   assign fall_norm = (fall_1 >= per) ? fall_1 - per : fall_1;

   assign sum    = $signed(rxtc_pkg::SUM_WIDTH'(rise_norm))
                 + $signed(rxtc_pkg::SUM_WIDTH'(fall_norm));
   assign half_s = $signed(rxtc_pkg::SUM_WIDTH'(period >> 1));
   assign per_s  = $signed(rxtc_pkg::SUM_WIDTH'(period));

   // When the two phases are equal, the falling phase is left out and only the rising phase
   // is halved.
   always_comb begin
      if (fall_norm > rise_norm) begin
         adj = sum - half_s;
      end else if (fall_norm < rise_norm) begin
         adj = sum + half_s;
      end else begin
         adj = $signed(rxtc_pkg::SUM_WIDTH'(rise_norm));
      end
   end

   // Halving that truncates toward zero.
   assign adj_round = adj + $signed(rxtc_pkg::SUM_WIDTH'(adj[rxtc_pkg::SUM_WIDTH-1]));
   assign halved    = adj_round >>> 1;

   always_comb begin
      if (halved[rxtc_pkg::SUM_WIDTH-1]) begin
         wrapped = halved + per_s;
      end else if (halved >= per_s) begin
         wrapped = halved - per_s;
      end else begin
         wrapped = halved;
      end
   end

   assign transition = wrapped[rxtc_pkg::SUM_WIDTH-1] ? '0
                                                      : wrapped[rxtc_pkg::TRANS_WIDTH-1:0];

endmodule

/* rtl/core/rx_timestamp_transition_calibrator_top.sv */
// An accepted request is loaded into the input register; its result is then loaded into the
// result register once that register is empty or is being drained.
// Throughput: one transaction per clock cycle while the result channel is not stalled, limited
// by the single state-update pass. Reset is synchronous and active high: it empties both
// registers, clears scan state and both detectors, and loads period, step, deglitch with 8000, 100, 5.
module rx_timestamp_transition_calibrator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic                                 req_flip_bit,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rxtc_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [rxtc_pkg::SETPOINT_WIDTH-1:0]  rsp_shift_setpoint,
   output logic [rxtc_pkg::TRANS_WIDTH-1:0]     rsp_transition_phase,
   output logic [rxtc_pkg::TRANS_WIDTH-1:0]     rsp_rising_phase,
   output logic [rxtc_pkg::TRANS_WIDTH-1:0]     rsp_falling_phase,
   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rxtc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [rxtc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [rxtc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

`include "rx_timestamp_transition_calibrator_top_macros.svh"

   // ---------------------------------------------------------------------------------------
   // Configuration registers. The step product and the scan range follow the registers
   // directly, so a write takes effect on the very next transaction.
   // ---------------------------------------------------------------------------------------
   logic [rxtc_pkg::PERIOD_WIDTH-1:0]  period_ff, period_in;
   logic [rxtc_pkg::STEP_WIDTH-1:0]    step_ff, step_in;
   logic [rxtc_pkg::COUNT_WIDTH-1:0]   deglitch_ff, deglitch_in;
   logic [rxtc_pkg::PRODUCT_WIDTH-1:0] step_product;
   logic [rxtc_pkg::RANGE_WIDTH-1:0]   scan_range;
   rxtc_pkg::csr_index_type            csr_index;
   logic                               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = rxtc_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      period_in   = period_ff;
      step_in     = step_ff;
      deglitch_in = deglitch_ff;
      csr_prdata  = '0;
      unique case (csr_index)
         rxtc_pkg::CSR_PERIOD: begin
            csr_prdata = rxtc_pkg::CSR_DATA_WIDTH'(period_ff);
            if (csr_write) begin
               period_in = csr_pwdata[rxtc_pkg::PERIOD_WIDTH-1:0];
            end
         end
         rxtc_pkg::CSR_STEP: begin
            csr_prdata = rxtc_pkg::CSR_DATA_WIDTH'(step_ff);
            if (csr_write) begin
               step_in = csr_pwdata[rxtc_pkg::STEP_WIDTH-1:0];
            end
         end
         rxtc_pkg::CSR_DEGLITCH: begin
            csr_prdata = rxtc_pkg::CSR_DATA_WIDTH'(deglitch_ff);
            if (csr_write) begin
               deglitch_in = csr_pwdata[rxtc_pkg::COUNT_WIDTH-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // The scan ends at one period plus three deglitch windows.
   assign step_product = rxtc_pkg::PRODUCT_WIDTH'(deglitch_ff)
                       * rxtc_pkg::PRODUCT_WIDTH'(step_ff);
   assign scan_range   = rxtc_pkg::RANGE_WIDTH'(period_ff)
                       + rxtc_pkg::RANGE_WIDTH'(step_product)
                       + (rxtc_pkg::RANGE_WIDTH'(step_product) << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= rxtc_pkg::PERIOD_RESET;
         step_ff     <= rxtc_pkg::STEP_RESET;
         deglitch_ff <= rxtc_pkg::DEGLITCH_RESET;
      end else begin
         period_ff   <= period_in;
         step_ff     <= step_in;
         deglitch_ff <= deglitch_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input register. A request is taken whenever the register is empty or is being drained
   // into the result register in the same cycle, so transactions flow back to back.
   // ---------------------------------------------------------------------------------------
   logic                 s1_valid_ff, s1_valid_in;
   rxtc_pkg::opcode_type s1_op_ff;
   logic                 s1_bit_ff;
   logic                 advance;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff  <= rxtc_pkg::opcode_type'(req_opcode);
         s1_bit_ff <= req_flip_bit;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Scan state update. A start clears the scan state and both detectors. A sample while
   // scanning feeds both detectors and then runs the end test against the phase it was taken
   // at. After the end, samples only repeat the final result.
   // ---------------------------------------------------------------------------------------
   logic [rxtc_pkg::PHASE_WIDTH-1:0] scan_phase_ff, scan_phase_in;
   rxtc_pkg::status_type             status_ff, status_in;
   logic [rxtc_pkg::TRANS_WIDTH-1:0] final_trans_ff, final_trans_in;
   logic                             is_start, sample_live, at_end, both_done;
   rxtc_pkg::det_ctrl_type           det_ctrl;
   rxtc_pkg::det_status_type         rise_st, fall_st;
   logic [rxtc_pkg::PHASE_WIDTH-1:0] rise_norm, fall_norm;
   logic [rxtc_pkg::TRANS_WIDTH-1:0] resolved;

   assign is_start    = (s1_op_ff == rxtc_pkg::OP_START);
   assign sample_live = !is_start && (status_ff == rxtc_pkg::STATUS_SCAN);
   assign at_end      = rxtc_pkg::CMP_WIDTH'(scan_phase_ff) >= rxtc_pkg::CMP_WIDTH'(scan_range);
   assign both_done   = (rise_st.mode_next == rxtc_pkg::MODE_DONE)
                     && (fall_st.mode_next == rxtc_pkg::MODE_DONE);

   assign det_ctrl.clear      = advance && is_start;
   assign det_ctrl.feed       = advance && sample_live;
   assign det_ctrl.store_norm = advance && sample_live && at_end && both_done;

   rxtc_det u_rise_det (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (det_ctrl),
      .sample_bit   (s1_bit_ff),
      .active_level (1'b1),
      .deglitch     (deglitch_ff),
      .scan_phase   (scan_phase_ff),
      .product      (step_product),
      .norm_edge    (rise_norm),
      .status       (rise_st)
   );

   rxtc_det u_fall_det (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (det_ctrl),
      .sample_bit   (s1_bit_ff),
      .active_level (1'b0),
      .deglitch     (deglitch_ff),
      .scan_phase   (scan_phase_ff),
      .product      (step_product),
      .norm_edge    (fall_norm),
      .status       (fall_st)
   );

   // Works on the edges as they stand after this sample, so an edge found on the very last
   // sample of the scan is folded in as well.
   rxtc_resolve u_resolve (
      .period     (period_ff),
      .rise_raw   (rise_st.edge_fed),
      .fall_raw   (fall_st.edge_fed),
      .rise_norm  (rise_norm),
      .fall_norm  (fall_norm),
      .transition (resolved)
   );

   always_comb begin
      scan_phase_in  = scan_phase_ff;
      status_in      = status_ff;
      final_trans_in = final_trans_ff;
      if (advance) begin
         if (is_start) begin
            scan_phase_in  = '0;
            status_in      = rxtc_pkg::STATUS_SCAN;
            final_trans_in = '0;
         end else if (sample_live) begin
            if (at_end) begin
               if (both_done) begin
                  status_in      = rxtc_pkg::STATUS_DONE;
                  final_trans_in = resolved;
               end else begin
                  status_in = rxtc_pkg::STATUS_ERROR;
               end
            end else begin
               // Wraps at the phase register width.
               scan_phase_in = scan_phase_ff + rxtc_pkg::PHASE_WIDTH'(step_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_phase_ff  <= '0;
         status_ff      <= rxtc_pkg::STATUS_SCAN;
         final_trans_ff <= '0;
      end else begin
         scan_phase_ff  <= scan_phase_in;
         status_ff      <= status_in;
         final_trans_ff <= final_trans_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result register. Every transaction yields one result, built from the state as it stands
   // after the update. Phase fields read zero unless the calibration is done.
   // ---------------------------------------------------------------------------------------
   logic [rxtc_pkg::STATUS_WIDTH-1:0]   rsp_status_ff;
   logic [rxtc_pkg::SETPOINT_WIDTH-1:0] rsp_setpoint_ff;
   logic [rxtc_pkg::TRANS_WIDTH-1:0]    rsp_transition_ff, rsp_rising_ff, rsp_falling_ff;
   logic                                done_next;

   assign done_next    = (status_in == rxtc_pkg::STATUS_DONE);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff     <= status_in;
         rsp_setpoint_ff   <= scan_phase_in[rxtc_pkg::SETPOINT_WIDTH-1:0];
         rsp_transition_ff <= done_next ? final_trans_in : '0;
         rsp_rising_ff     <= done_next ? rise_st.edge_next[rxtc_pkg::TRANS_WIDTH-1:0] : '0;
         rsp_falling_ff    <= done_next ? fall_st.edge_next[rxtc_pkg::TRANS_WIDTH-1:0] : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_shift_setpoint   = rsp_setpoint_ff;
   assign rsp_transition_phase = rsp_transition_ff;
   assign rsp_rising_phase     = rsp_rising_ff;
   assign rsp_falling_phase    = rsp_falling_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------
   `RXTC_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_ready, "request stalled with empty result register")
   `RXTC_ASSERT_NOW(a_phases_only_when_done, clock, reset, rsp_valid_ff && (rsp_status_ff != rxtc_pkg::STATUS_DONE), (rsp_transition_ff == '0) && (rsp_rising_ff == '0) && (rsp_falling_ff == '0), "phase fields nonzero without done status")
   `RXTC_ASSERT_NEXT(a_frozen_after_end, clock, reset, advance && (s1_op_ff == rxtc_pkg::OP_SAMPLE) && (status_ff != rxtc_pkg::STATUS_SCAN), $stable(scan_phase_ff) && $stable(status_ff) && $stable(final_trans_ff), "scan state changed after the scan ended")
   `RXTC_ASSERT_NEXT(a_start_clears, clock, reset, advance && (s1_op_ff == rxtc_pkg::OP_START), (scan_phase_ff == '0) && (status_ff == rxtc_pkg::STATUS_SCAN) && rsp_valid_ff, "start did not clear the scan")
   `RXTC_ASSERT_NOW(a_done_has_edges, clock, reset, (status_ff == rxtc_pkg::STATUS_DONE) && !det_ctrl.clear, (rise_st.mode_next == rxtc_pkg::MODE_DONE) && (fall_st.mode_next == rxtc_pkg::MODE_DONE), "done status with an unfinished detector")

endmodule
